@@ hdl/lsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants of the Lax advection stencil step
// Register indexes, boundary mode codes and the job descriptor that travels
// from the stencil window through the lanes to the result buffer.
// ----------------------------------------------------------------------------
package lsa_pkg;

   localparam int LANES         = 3;
   localparam int INDEX_BITS    = 12;
   localparam int COUNT_BITS    = 13;
   localparam int RHO_BITS      = 18;
   localparam int MODE_BITS     = 2;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 18;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_POINT_COUNT   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COURANT_HALF  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BOUNDARY_MODE = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_FIXED    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_PERIODIC = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FREE     = 2'd2;

   localparam logic [COUNT_BITS-1:0] POINT_COUNT_RESET = 13'd4096;

   typedef logic [INDEX_BITS-1:0] index_type;

   // one result slot: grid index, and copy = pass operand a unchanged
   typedef struct packed {
      index_type idx;
      logic      copy;
   } lane_ctl_type;

   // count = number of result slots in use (1..3), lanes filled from 0
   typedef struct packed {
      logic [1:0]                    count;
      lane_ctl_type [LANES-1:0]      lane;
   } job_type;

endpackage

@@ hdl/lax_advection_stencil_step_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lax_advection_stencil_step_core: streaming Lax-Friedrichs advection update
// One Q16.16 grid sample per beat in; Lax updates with their grid index out,
// with fixed, periodic or free boundary handling.
//
//   channel  dir  handshake               payload
//   req_     in   req_valid / req_ready   req_sample
//   rsp_     out  rsp_valid / rsp_ready   rsp_point_index, rsp_new_value,
//                                         rsp_last_of_run
//   csr_     in   csr_we                  csr_index, csr_wdata
//
// One sample accepted per cycle while req_ready is high; the first result of a
// sample passes the job register, lane product register and result buffer.
// A sample causing k results holds the result buffer for k beats, so the
// single output port sets the throughput: N samples of a row give N results.
// Reset is synchronous; it restarts the row and restores register defaults.
// A stalled rsp_ready backs up through the three stages into req_ready.
// ----------------------------------------------------------------------------
module lax_advection_stencil_step_core
   import lsa_pkg::*;
#(
   parameter int MAX_POINTS  = 4096,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [INDEX_BITS-1:0]     rsp_point_index,
   output logic [SAMPLE_BITS-1:0]    rsp_new_value,
   output logic                      rsp_last_of_run,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [COUNT_BITS-1:0]       point_count_ff;
   logic signed [RHO_BITS-1:0]  courant_half_ff;
   logic [MODE_BITS-1:0]        boundary_mode_ff;

   logic                                job_valid, job_ready;
   job_type                             job;
   logic [LANES-1:0][SAMPLE_BITS-1:0]   job_a, job_b;

   logic                                s2_valid_ff, s2_valid_in;
   job_type                             s2_job_ff;
   logic                                s2_ready, s2_move;
   logic [LANES-1:0][SAMPLE_BITS-1:0]   lane_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= POINT_COUNT_RESET;
         courant_half_ff  <= '0;
         boundary_mode_ff <= MODE_FIXED;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POINT_COUNT:   point_count_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_COURANT_HALF:  courant_half_ff  <= $signed(csr_wdata[RHO_BITS-1:0]);
            CSR_BOUNDARY_MODE: boundary_mode_ff <= csr_wdata[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   lsa_window #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .point_count   (point_count_ff),
      .boundary_mode (boundary_mode_ff),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job           (job),
      .job_a         (job_a),
      .job_b         (job_b)
   );

   assign job_ready = !s2_valid_ff || s2_ready;
   assign s2_move   = job_valid && job_ready;

   always_comb begin
      if (s2_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s2_job_ff <= job;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      lsa_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock (clock),
         .load  (s2_move),
         .a     (job_a[g]),
         .b     (job_b[g]),
         .copy  (job.lane[g].copy),
         .rho   (courant_half_ff),
         .value (lane_value[g])
      );
   end

   lsa_drain #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_drain (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_valid_ff),
      .in_ready        (s2_ready),
      .in_job          (s2_job_ff),
      .in_value        (lane_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_new_value   (rsp_new_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a held job blocks new samples
   a_job_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (job_valid && !job_ready) |-> !req_ready)
      else $error("sample accepted while job register stalled");

   // a job in the lane stage waits until the buffer takes it
   a_lane_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_ready) |=> s2_valid_ff)
      else $error("lane stage dropped a job");

   // beats of one job follow without a gap
   a_job_beats_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("result beat missing inside a job");

   a_reset_clears_output : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

@@ hdl/lsa_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_window: row position, sample window and job register
// Tracks the position in the row and the recent samples, decides which
// results an incoming sample causes and registers them as one job.
// ----------------------------------------------------------------------------
module lsa_window
   import lsa_pkg::*;
#(
   parameter int MAX_POINTS  = 4096,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   input  logic [COUNT_BITS-1:0]                 point_count,
   input  logic [MODE_BITS-1:0]                  boundary_mode,
   output logic                                  job_valid,
   input  logic                                  job_ready,
   output job_type                               job,
   output logic [LANES-1:0][SAMPLE_BITS-1:0]     job_a,
   output logic [LANES-1:0][SAMPLE_BITS-1:0]     job_b
);

   localparam int POS_BITS = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = (POS_BITS + 1 > COUNT_BITS) ? POS_BITS + 1 : COUNT_BITS;

   logic [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [SAMPLE_BITS-1:0] second_ff, second_in;
   logic [SAMPLE_BITS-1:0] older_ff;
   logic [SAMPLE_BITS-1:0] newer_ff;
   logic [POS_BITS-1:0]    pos_ff, pos_in;

   logic                                job_valid_ff, job_valid_in;
   job_type                             job_ff, job_in;
   logic [LANES-1:0][SAMPLE_BITS-1:0]   job_a_ff, job_a_in;
   logic [LANES-1:0][SAMPLE_BITS-1:0]   job_b_ff, job_b_in;

   logic          accept;
   logic [CW-1:0] pc_w, n_eff, pos_w, pos_next_w, pos_prev_w;
   logic          last;
   logic          mode_periodic, mode_free, mode_fixed;
   index_type     idx_cur, idx_prev;

   assign accept    = req_valid && req_ready;
   assign req_ready = !job_valid_ff || job_ready;
   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign job_a     = job_a_ff;
   assign job_b     = job_b_ff;

   // effective row length; out-of-range lengths clamp
   always_comb begin
      pc_w = CW'(point_count);
      if (pc_w < CW'(3)) begin
         n_eff = CW'(3);
      end else if (pc_w > CW'(MAX_POINTS)) begin
         n_eff = CW'(MAX_POINTS);
      end else begin
         n_eff = pc_w;
      end
   end

   assign pos_w      = CW'(pos_ff);
   assign pos_next_w = pos_w + CW'(1);
   assign pos_prev_w = pos_w - CW'(1);
   assign last       = pos_next_w >= n_eff;
   assign idx_cur    = pos_w[INDEX_BITS-1:0];
   assign idx_prev   = pos_prev_w[INDEX_BITS-1:0];

   // mode 3 behaves as fixed ends
   always_comb begin
      mode_periodic = 1'b0;
      mode_free     = 1'b0;
      unique case (boundary_mode)
         MODE_PERIODIC: mode_periodic = 1'b1;
         MODE_FREE:     mode_free     = 1'b1;
         default:       mode_periodic = 1'b0;
      endcase
      mode_fixed = !mode_periodic && !mode_free;
   end

   // result slots caused by the current sample
   always_comb begin
      logic [1:0] k;
      k        = 2'd0;
      job_in   = '0;
      job_a_in = '0;
      job_b_in = '0;
      if (pos_ff == '0) begin
         if (mode_fixed) begin
            job_in.lane[0] = '{idx: '0, copy: 1'b1};
            job_a_in[0]    = req_sample;
            k              = 2'd1;
         end
      end else if (pos_ff != POS_BITS'(1)) begin
         if (mode_free && pos_w == CW'(2)) begin
            job_in.lane[k] = '{idx: '0, copy: 1'b0};
            job_a_in[k]    = req_sample;
            job_b_in[k]    = older_ff;
            k              = k + 2'd1;
         end
         job_in.lane[k] = '{idx: idx_prev, copy: 1'b0};
         job_a_in[k]    = req_sample;
         job_b_in[k]    = older_ff;
         k              = k + 2'd1;
         if (last) begin
            if (mode_periodic) begin
               job_in.lane[k] = '{idx: idx_cur, copy: 1'b0};
               job_a_in[k]    = first_ff;
               job_b_in[k]    = newer_ff;
               k              = k + 2'd1;
               job_in.lane[k] = '{idx: '0, copy: 1'b0};
               job_a_in[k]    = second_ff;
               job_b_in[k]    = req_sample;
               k              = k + 2'd1;
            end else begin
               // fixed copies the end sample, free repeats the interior result
               job_in.lane[k] = '{idx: idx_cur, copy: mode_fixed};
               job_a_in[k]    = req_sample;
               job_b_in[k]    = older_ff;
               k              = k + 2'd1;
            end
         end
      end
      job_in.count = k;
   end

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (pos_ff == '0) begin
         first_in = req_sample;
      end
      if (pos_ff == POS_BITS'(1)) begin
         second_in = req_sample;
      end
      pos_in = last ? '0 : pos_next_w[POS_BITS-1:0];
   end

   // jobs without results are dropped here
   always_comb begin
      if (accept && job_in.count != 2'd0) begin
         job_valid_in = 1'b1;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         second_ff    <= '0;
         older_ff     <= '0;
         newer_ff     <= '0;
         pos_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         if (accept) begin
            first_ff  <= first_in;
            second_ff <= second_in;
            older_ff  <= newer_ff;
            newer_ff  <= req_sample;
            pos_ff    <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff   <= job_in;
         job_a_ff <= job_a_in;
         job_b_ff <= job_b_in;
      end
   end

endmodule

@@ hdl/lsa_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_lane: one Lax update lane
// Registers (a+b)/2 and rho*(a-b), then subtracts the scaled product and
// saturates. A copy slot forces the product to zero and passes a.
// ----------------------------------------------------------------------------
module lsa_lane
   import lsa_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [SAMPLE_BITS-1:0]      a,
   input  logic [SAMPLE_BITS-1:0]      b,
   input  logic                        copy,
   input  logic signed [RHO_BITS-1:0]  rho,
   output logic [SAMPLE_BITS-1:0]      value
);

   localparam int PW = SAMPLE_BITS + 1 + RHO_BITS;
   localparam int RW = SAMPLE_BITS + 4;
   localparam logic signed [RW-1:0] MAX_V = RW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RW-1:0] MIN_V = -MAX_V - RW'(1);

   logic signed [SAMPLE_BITS-1:0] half_ff, half_in;
   logic signed [PW-1:0]          prod_ff, prod_in;

   logic signed [SAMPLE_BITS:0]   sum, diff;
   logic signed [PW-1:0]          term;
   logic signed [RW-1:0]          r;

   always_comb begin
      sum  = (SAMPLE_BITS+1)'($signed(a)) + (SAMPLE_BITS+1)'($signed(b));
      diff = (SAMPLE_BITS+1)'($signed(a)) - (SAMPLE_BITS+1)'($signed(b));
      if (copy) begin
         half_in = $signed(a);
         prod_in = '0;
      end else begin
         half_in = sum[SAMPLE_BITS:1];
         prod_in = PW'(rho) * PW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         half_ff <= half_in;
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      term = prod_ff >>> FRAC_BITS;
      r    = RW'(half_ff) - RW'(term);
      if (r > MAX_V) begin
         value = MAX_V[SAMPLE_BITS-1:0];
      end else if (r < MIN_V) begin
         value = MIN_V[SAMPLE_BITS-1:0];
      end else begin
         value = r[SAMPLE_BITS-1:0];
      end
   end

endmodule

@@ hdl/lsa_drain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_drain: result buffer
// Holds the finished results of one job and hands them out one beat at a
// time, flagging the final beat of the job.
// ----------------------------------------------------------------------------
module lsa_drain
   import lsa_pkg::*;
#(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  job_type                             in_job,
   input  logic [LANES-1:0][SAMPLE_BITS-1:0]   in_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [INDEX_BITS-1:0]               rsp_point_index,
   output logic [SAMPLE_BITS-1:0]              rsp_new_value,
   output logic                                rsp_last_of_run
);

   logic                              valid_ff, valid_in;
   logic [1:0]                        ptr_ff, ptr_in;
   job_type                           job_ff;
   logic [LANES-1:0][SAMPLE_BITS-1:0] value_ff;

   logic last_beat, take, load;

   assign last_beat = ptr_ff == (job_ff.count - 2'd1);
   assign take      = valid_ff && rsp_ready;
   assign in_ready  = !valid_ff || (rsp_ready && last_beat);
   assign load      = in_valid && in_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_point_index = job_ff.lane[ptr_ff].idx;
   assign rsp_new_value   = value_ff[ptr_ff];
   assign rsp_last_of_run = last_beat;

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (load) begin
         valid_in = 1'b1;
         ptr_in   = 2'd0;
      end else if (take) begin
         valid_in = !last_beat;
         ptr_in   = ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff   <= in_job;
         value_ff <= in_value;
      end
   end

endmodule

@@ dv/lax_advection_stencil_step_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lax_advection_stencil_step_core_tb: self-checking bench for the Lax stencil
// Streams grid rows through the core under fixed, periodic and free boundary
// handling. A directed table covers the extremes, the saturation and the
// clamping of the row length. Random rows follow, some of them cut short,
// under shifting idle patterns on both channels. Every result beat is
// compared with a local Lax-Friedrichs predictor, field by field.
// ----------------------------------------------------------------------------
module lax_advection_stencil_step_core_tb
   import lsa_pkg::*;
();

   localparam int SAMPLE_W      = 32;
   localparam int MAX_ROW       = 4096;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_ITEMS   = 60;
   localparam logic [MODE_BITS-1:0] MODE_UNKNOWN = 2'd3;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef struct packed {
      index_type             point_index;
      logic [SAMPLE_W-1:0]   new_value;
      logic                  last_of_run;
   } stencil_beat_type;

   typedef enum logic {STEP_SAMPLE, STEP_CSR} plan_kind_type;

   typedef struct packed {
      plan_kind_type             kind;
      logic [CSR_ADDR_BITS-1:0]  addr;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [SAMPLE_W-1:0]       grid_value;
      logic                      typed;
      index_type                 typed_index;
      logic [SAMPLE_W-1:0]       typed_value;
   } plan_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [SAMPLE_W-1:0]       req_sample;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [INDEX_BITS-1:0]     rsp_point_index;
   logic [SAMPLE_W-1:0]       rsp_new_value;
   logic                      rsp_last_of_run;
   logic                      csr_we;
   logic [CSR_ADDR_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // predictor copy of the registers and of the stencil window
   logic [COUNT_BITS-1:0]     grid_points = POINT_COUNT_RESET;
   logic signed [RHO_BITS-1:0] rho       = '0;
   logic [MODE_BITS-1:0]      bound_mode = MODE_FIXED;
   logic signed [SAMPLE_W-1:0] row_first  = '0;
   logic signed [SAMPLE_W-1:0] row_second = '0;
   logic signed [SAMPLE_W-1:0] prev_older = '0;
   logic signed [SAMPLE_W-1:0] prev_newer = '0;
   int unsigned               row_pos    = 0;

   stencil_beat_type pending_beats[$];
   plan_row_type     directed_plan[$];
   int            error_count   = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   bit            hold_request  = 0;

   lax_advection_stencil_step_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_new_value   (rsp_new_value),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // (a+b)/2 - rho*(a-b), both shifts flooring, saturated to 32 bits
   function automatic logic signed [SAMPLE_W-1:0] lax_update(
      input logic signed [SAMPLE_W-1:0] a, input logic signed [SAMPLE_W-1:0] b);
      longint wa, wb, mid, drift, r;
      wa = longint'(a);
      wb = longint'(b);
      mid = (wa + wb) >>> 1;
      drift = (longint'(rho) * (wa - wb)) >>> FRAC_BITS;
      r = mid - drift;
      if (r > VALUE_MAX) r = VALUE_MAX;
      else if (r < VALUE_MIN) r = VALUE_MIN;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic void emit_beat(input int unsigned idx, input logic [SAMPLE_W-1:0] val);
      stencil_beat_type b;
      b.point_index = INDEX_BITS'(idx);
      b.new_value   = val;
      b.last_of_run = 1'b0;
      pending_beats.push_back(b);
   endfunction

   // advances the window by one sample, queues its results, returns how many
   function automatic int predict_stencil(input logic [SAMPLE_W-1:0] grid_in);
      int unsigned span, p;
      logic [MODE_BITS-1:0] mode;
      logic at_end;
      logic signed [SAMPLE_W-1:0] s, v;
      int made;
      s = grid_in;
      made = pending_beats.size();
      span = 32'(grid_points);
      if (span < 3) span = 3;
      if (span > MAX_ROW) span = MAX_ROW;
      mode = (bound_mode == MODE_UNKNOWN) ? MODE_FIXED : bound_mode;
      p = row_pos;
      at_end = (p + 1 >= span);
      if (p == 0) begin
         row_first = s;
         if (mode == MODE_FIXED) emit_beat(0, s);
      end else if (p == 1) begin
         row_second = s;
      end else begin
         v = lax_update(s, prev_older);
         if (mode == MODE_FREE && p == 2) emit_beat(0, v);
         emit_beat(p - 1, v);
         if (at_end) begin
            if (mode == MODE_FIXED) begin
               emit_beat(p, s);
            end else if (mode == MODE_FREE) begin
               emit_beat(p, v);
            end else begin
               // periodic: wrap the right end, then index 0 comes last
               emit_beat(p, lax_update(row_first, prev_newer));
               emit_beat(0, lax_update(row_second, s));
            end
         end
      end
      prev_older = prev_newer;
      prev_newer = s;
      row_pos = at_end ? 0 : p + 1;
      made = pending_beats.size() - made;
      if (made > 0) pending_beats[pending_beats.size() - 1].last_of_run = 1'b1;
      return made;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_row_length();
      int r;
      r = $urandom_range(99);
      if (r < 8) return CSR_DATA_BITS'($urandom_range(2));
      if (r < 85) return CSR_DATA_BITS'($urandom_range(10, 3));
      return CSR_DATA_BITS'($urandom_range(40, 11));
   endfunction

   task automatic plan_row(input plan_kind_type kind, input logic [CSR_ADDR_BITS-1:0] addr,
                           input logic [CSR_DATA_BITS-1:0] data,
                           input logic [SAMPLE_W-1:0] grid_value, input logic typed,
                           input index_type typed_index,
                           input logic [SAMPLE_W-1:0] typed_value);
      plan_row_type row;
      row.kind        = kind;
      row.addr        = addr;
      row.data        = data;
      row.grid_value  = grid_value;
      row.typed       = typed;
      row.typed_index = typed_index;
      row.typed_value = typed_value;
      directed_plan.push_back(row);
   endtask

   task automatic offer_sample(input logic [SAMPLE_W-1:0] grid_value, output int produced);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_sample <= grid_value;
      do @(posedge clock); while (!req_ready);
      produced = predict_stencil(grid_value);
   endtask

   // registers change only with the core drained
   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_POINT_COUNT:   grid_points = data[COUNT_BITS-1:0];
         CSR_COURANT_HALF:  rho = data[RHO_BITS-1:0];
         CSR_BOUNDARY_MODE: bound_mode = data[MODE_BITS-1:0];
         default: ;
      endcase
   endtask

   // result side: checks each beat, then picks ready for the next edge
   initial begin
      int stall_left;
      stencil_beat_type want;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               error_count++;
               $error("result beat with nothing expected: point_index %0d new_value %h",
                      rsp_point_index, rsp_new_value);
            end else begin
               want = pending_beats.pop_front();
               if (rsp_point_index !== want.point_index) begin
                  error_count++;
                  $error("point_index: expected %0d, got %0d",
                         want.point_index, rsp_point_index);
               end
               if (rsp_new_value !== want.new_value) begin
                  error_count++;
                  $error("new_value: expected %h, got %h", want.new_value, rsp_new_value);
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  error_count++;
                  $error("last_of_run: expected %0b, got %0b",
                         want.last_of_run, rsp_last_of_run);
               end
            end
         end
         if (hold_request) begin
            stall_left   = HOLD_CYCLES;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      plan_row_type row;
      int produced, phase, phase_items, sent, cut_at, r;
      bit cut;
      logic [SAMPLE_W-1:0] pick_value;
      logic [CSR_DATA_BITS-1:0] rho_pick;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_sample <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_POINT_COUNT;
      csr_wdata  <= '0;

      // fixed ends, full-length row, rho 0 out of reset
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h7FFF_FFFF, 1'b1, 12'd0, 32'h7FFF_FFFF);
      // length below 3 acts as 3
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd2, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h7FFF_FFFF, 1'b1, 12'd1, 32'h7FFF_FFFF);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b1, 12'd0, 32'h8000_0000);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0000_0001, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b1, 12'd1, 32'h8000_0000);
      // periodic at the largest rho: wrapped ends saturate both ways
      plan_row(STEP_CSR, CSR_COURANT_HALF, 18'h1FFFF, '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_BOUNDARY_MODE, CSR_DATA_BITS'(MODE_PERIODIC), '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd3, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h7FFF_FFFF, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b0, '0, '0);
      // free ends at the most negative rho
      plan_row(STEP_CSR, CSR_COURANT_HALF, 18'h20000, '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_BOUNDARY_MODE, CSR_DATA_BITS'(MODE_FREE), '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd4, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0000_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'hFFFF_FFFF, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h1234_5678, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h8000_0000, 1'b0, '0, '0);
      // unknown mode behaves as fixed; oversize length clamps to the max
      plan_row(STEP_CSR, CSR_BOUNDARY_MODE, CSR_DATA_BITS'(MODE_UNKNOWN), '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd8191, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0001_0000, 1'b1, 12'd0, 32'h0001_0000);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'hFFFF_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h7FFF_8000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0000_8000, 1'b0, '0, '0);
      // row shortened past the current position: next sample closes the row
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd3, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0000_FFFF, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd4096, '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_COURANT_HALF, 18'h00800, '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_BOUNDARY_MODE, CSR_DATA_BITS'(MODE_PERIODIC), '0, 1'b0, '0, '0);
      plan_row(STEP_CSR, CSR_POINT_COUNT, 18'd5, '0, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0001_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0002_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'hFFFE_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0005_0000, 1'b0, '0, '0);
      plan_row(STEP_SAMPLE, CSR_POINT_COUNT, '0, 32'h0000_0000, 1'b0, '0, '0);

      send_idle_pct = 13;
      recv_idle_pct = 83;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == STEP_CSR) begin
            write_csr(row.addr, row.data);
         end else begin
            offer_sample(row.grid_value, produced);
            if (row.typed && produced > 0) begin
               pending_beats[pending_beats.size() - produced].point_index = row.typed_index;
               pending_beats[pending_beats.size() - produced].new_value   = row.typed_value;
            end
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long row against a stalled output so the pipe backs up
               write_csr(CSR_POINT_COUNT, 18'd24);
               hold_request = 1;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (!(phase == 2 && phase_items == 0)) begin
               if ($urandom_range(9) < 4) write_csr(CSR_POINT_COUNT, pick_row_length());
               if ($urandom_range(9) < 3) begin
                  r = $urandom_range(99);
                  if (r < 15) rho_pick = 18'h1FFFF;
                  else if (r < 30) rho_pick = 18'h20000;
                  else if (r < 40) rho_pick = '0;
                  else rho_pick = CSR_DATA_BITS'($urandom);
                  write_csr(CSR_COURANT_HALF, rho_pick);
               end
               if ($urandom_range(9) < 3)
                  write_csr(CSR_BOUNDARY_MODE, CSR_DATA_BITS'($urandom_range(3)));
            end
            cut    = ($urandom_range(9) == 0);
            cut_at = $urandom_range(6, 1);
            sent   = 0;
            do begin
               r = $urandom_range(99);
               if (r < 55) begin
                  pick_value = $urandom;
               end else if (r < 85) begin
                  // smooth field within +-8.0
                  pick_value = $urandom_range(32'h000F_FFFF) - 32'h0007_FFFF;
               end else begin
                  case ($urandom_range(3))
                     0: pick_value = 32'h7FFF_FFFF;
                     1: pick_value = 32'h8000_0000;
                     2: pick_value = 32'h0000_0000;
                     default: pick_value = 32'hFFFF_FFFF;
                  endcase
               end
               offer_sample(pick_value, produced);
               sent++;
               phase_items++;
            end while (row_pos != 0 && !(cut && sent >= cut_at));
            // broken row: change the length with the row still open
            if (row_pos != 0) write_csr(CSR_POINT_COUNT, pick_row_length());
         end
      end

      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
